>>> rtl/thb_pkg.sv
// thb_pkg: widths, register codes, reset values and the config struct shared by
// the three-band column height core and its submodules.
// no dependencies
package thb_pkg;

    localparam int LVL_W      = 8;
    localparam int SQ_W       = 16;
    localparam int SUM_W      = 18;
    localparam int GAIN_W     = 12;
    localparam int GSQ_W      = 24;
    localparam int OUT_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [GAIN_W-1:0] LOW_GAIN_RST  = 12'd1178;
    localparam logic [GAIN_W-1:0] MID_GAIN_RST  = 12'd1905;
    localparam logic [GAIN_W-1:0] HIGH_GAIN_RST = 12'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_GAIN  = 2'd0,
        CFG_MID_GAIN  = 2'd1,
        CFG_HIGH_GAIN = 2'd2,
        CFG_MONO_MODE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GSQ_W-1:0] low_gsq;
        logic [GSQ_W-1:0] mid_gsq;
        logic [GSQ_W-1:0] high_gsq;
        logic             mono;
    } t_cfg;

endpackage

>>> rtl/thb_in_if.sv
// thb_in_if: valid/ready channel carrying one overview column (six band levels)
// depends on thb_pkg
interface thb_in_if import thb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] low_left;
    logic [LVL_W-1:0] low_right;
    logic [LVL_W-1:0] mid_left;
    logic [LVL_W-1:0] mid_right;
    logic [LVL_W-1:0] high_left;
    logic [LVL_W-1:0] high_right;

    modport source (
        output valid, low_left, low_right, mid_left, mid_right, high_left, high_right,
        input  ready
    );
    modport sink (
        input  valid, low_left, low_right, mid_left, mid_right, high_left, high_right,
        output ready
    );
endinterface

>>> rtl/thb_out_if.sv
// thb_out_if: valid/ready channel carrying the four layer extents of one column
// depends on thb_pkg
interface thb_out_if import thb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] low_extent;
    logic [OUT_W-1:0] mid_extent;
    logic [OUT_W-1:0] low_mid_extent;
    logic [OUT_W-1:0] high_extent;

    modport source (
        output valid, low_extent, mid_extent, low_mid_extent, high_extent,
        input  ready
    );
    modport sink (
        input  valid, low_extent, mid_extent, low_mid_extent, high_extent,
        output ready
    );
endinterface

>>> rtl/thb_cfg.sv
// thb_cfg: gain and mode registers with registered gain squares
// depends on thb_pkg
module thb_cfg import thb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [GAIN_W-1:0] r_low_gain;
    logic [GAIN_W-1:0] r_mid_gain;
    logic [GAIN_W-1:0] r_high_gain;
    logic              r_mono;
    logic [GSQ_W-1:0]  r_low_gsq;
    logic [GSQ_W-1:0]  r_mid_gsq;
    logic [GSQ_W-1:0]  r_high_gsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_gain  <= LOW_GAIN_RST;
            r_mid_gain  <= MID_GAIN_RST;
            r_high_gain <= HIGH_GAIN_RST;
            r_mono      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOW_GAIN:  r_low_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_MID_GAIN:  r_mid_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_HIGH_GAIN: r_high_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_MONO_MODE: r_mono      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_low_gsq  <= GSQ_W'(r_low_gain)  * GSQ_W'(r_low_gain);
        r_mid_gsq  <= GSQ_W'(r_mid_gain)  * GSQ_W'(r_mid_gain);
        r_high_gsq <= GSQ_W'(r_high_gain) * GSQ_W'(r_high_gain);
    end

    assign o_cfg.low_gsq  = r_low_gsq;
    assign o_cfg.mid_gsq  = r_mid_gsq;
    assign o_cfg.high_gsq = r_high_gsq;
    assign o_cfg.mono     = r_mono;

endmodule

>>> rtl/thb_band.sv
// thb_band: one band's energy scaling: gain square times sum of squares, fixed
// point alignment and clamp to the squared height cap; two register stages
// depends on thb_pkg
module thb_band import thb_pkg::*; #(
    parameter int FRAC = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [GSQ_W-1:0]         i_gsq,
    input  logic [SUM_W-1:0]         i_sumsq,
    input  logic                     i_mono,
    output logic [2*(FRAC+9)-1:0]    o_x
);

    localparam int NW   = GSQ_W + SUM_W;
    localparam int E0   = 2 * FRAC - 21;
    localparam int E1   = E0 + 2;
    localparam int SH0L = (E0 > 0) ? E0 : 0;
    localparam int SH0R = (E0 < 0) ? -E0 : 0;
    localparam int SH1L = (E1 > 0) ? E1 : 0;
    localparam int SH1R = (E1 < 0) ? -E1 : 0;
    localparam int XW   = NW + SH1L;
    localparam int CW   = 2 * (FRAC + 9);
    localparam longint unsigned CAP0 = 64'd255 << FRAC;
    localparam longint unsigned CAP1 = 64'd510 << FRAC;
    localparam logic [XW-1:0] CAPSQ0 = XW'(CAP0 * CAP0);
    localparam logic [XW-1:0] CAPSQ1 = XW'(CAP1 * CAP1);

    logic [NW-1:0] r_n;
    logic          r_mono;
    logic [XW-1:0] w_x0;
    logic [XW-1:0] w_x1;
    logic [XW-1:0] w_x;
    logic [XW-1:0] w_cap;
    logic [CW-1:0] r_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= NW'(i_gsq) * NW'(i_sumsq);
            r_mono <= i_mono;
        end
    end

    always_comb begin
        w_x0  = (XW'(r_n) << SH0L) >> SH0R;
        w_x1  = (XW'(r_n) << SH1L) >> SH1R;
        w_x   = r_mono ? w_x1 : w_x0;
        w_cap = r_mono ? CAPSQ1 : CAPSQ0;
    end

    // clamping before the root equals clamping the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= (w_x >= w_cap) ? CW'(w_cap) : CW'(w_x);
        end
    end

    assign o_x = r_x;

endmodule

>>> rtl/thb_isqrt.sv
// thb_isqrt: pipelined integer square root, one result bit per register stage
// depends on thb_pkg
module thb_isqrt import thb_pkg::*; #(
    parameter int RW = 17
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_x,
    output logic [RW-1:0]   o_root
);

    logic [RW:0]     r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_x    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic [RW:0]     w_rem_in;
        logic [RW-1:0]   w_root_in;
        logic [2*RW-1:0] w_x_in;
        logic [RW+2:0]   w_rem_sh;
        logic [RW+2:0]   w_trial;
        logic            w_take;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_x_in    = i_x;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_x_in    = r_x[k-1];
        end

        always_comb begin
            w_rem_sh = {w_rem_in, w_x_in[2*RW-1:2*RW-2]};
            w_trial  = {1'b0, w_root_in, 2'b01};
            w_take   = (w_rem_sh >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? (RW+1)'(w_rem_sh - w_trial) : (RW+1)'(w_rem_sh);
                r_root[k] <= {w_root_in[RW-2:0], w_take};
                r_x[k]    <= w_x_in << 2;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

>>> rtl/waveform_three_band_heights_core.sv
// Three-band overview column height core: squares, energy sums, per-band
// scaling lanes, pipelined square roots and the output register.
// depends on thb_pkg, thb_in_if, thb_out_if, thb_cfg, thb_band, thb_isqrt
//
// One column item is taken every cycle while the pipeline advances. Its stages
// are squaring, summing, gain multiply, alignment/clamp, the square root
// pipeline, which spends one register stage on each of its HEIGHT_FRAC_BITS + 9
// result bits, and the output register. The whole pipeline advances when
// the output register is empty or being taken, so a stall on the result side
// holds every item in place. The user must write gains and mode through the
// configuration port only while no item is in flight; the block itself does
// not enforce this. A gain write takes effect for items accepted from the next
// cycle on.
module waveform_three_band_heights_core import thb_pkg::*; #(
    parameter int HEIGHT_FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    thb_in_if.sink                i_in,
    thb_out_if.source             o_out
);

    localparam int RW  = HEIGHT_FRAC_BITS + 9;
    localparam int CW  = 2 * RW;
    localparam int TOT = RW + 5;
    localparam logic [OUT_W-1:0] CAP_OUT = OUT_W'(64'd255 << HEIGHT_FRAC_BITS);

    t_cfg              w_cfg;
    logic              w_adv;
    logic [TOT-1:0]    r_vld;
    logic [TOT-1:0]    r_mono;
    logic [SQ_W-1:0]   r_sq [6];
    logic [SUM_W-1:0]  r_s_low;
    logic [SUM_W-1:0]  r_s_mid;
    logic [SUM_W-1:0]  r_s_mh;
    logic [CW-1:0]     w_x_low;
    logic [CW-1:0]     w_x_mid;
    logic [CW-1:0]     w_x_high;
    logic [RW-1:0]     w_rt_low;
    logic [RW-1:0]     w_rt_mid;
    logic [RW-1:0]     w_rt_high;
    logic [RW-1:0]     w_rt_min;
    logic [OUT_W-1:0]  r_lo;
    logic [OUT_W-1:0]  r_mi;
    logic [OUT_W-1:0]  r_lm;
    logic [OUT_W-1:0]  r_hi;

    thb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_adv      = !r_vld[TOT-1] || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[TOT-2:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mono <= {r_mono[TOT-2:0], w_cfg.mono};
        end
    end

    // level squares
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq[0] <= SQ_W'(i_in.low_left)   * SQ_W'(i_in.low_left);
            r_sq[1] <= SQ_W'(i_in.low_right)  * SQ_W'(i_in.low_right);
            r_sq[2] <= SQ_W'(i_in.mid_left)   * SQ_W'(i_in.mid_left);
            r_sq[3] <= SQ_W'(i_in.mid_right)  * SQ_W'(i_in.mid_right);
            r_sq[4] <= SQ_W'(i_in.high_left)  * SQ_W'(i_in.high_left);
            r_sq[5] <= SQ_W'(i_in.high_right) * SQ_W'(i_in.high_right);
        end
    end

    // band energies, high layer uses mid plus high
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_low <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]);
            r_s_mid <= SUM_W'(r_sq[2]) + SUM_W'(r_sq[3]);
            r_s_mh  <= SUM_W'(r_sq[2]) + SUM_W'(r_sq[3]) + SUM_W'(r_sq[4]) + SUM_W'(r_sq[5]);
        end
    end

    thb_band #(.FRAC(HEIGHT_FRAC_BITS)) u_band_low (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_gsq   (w_cfg.low_gsq),
        .i_sumsq (r_s_low),
        .i_mono  (r_mono[1]),
        .o_x     (w_x_low)
    );

    thb_band #(.FRAC(HEIGHT_FRAC_BITS)) u_band_mid (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_gsq   (w_cfg.mid_gsq),
        .i_sumsq (r_s_mid),
        .i_mono  (r_mono[1]),
        .o_x     (w_x_mid)
    );

    thb_band #(.FRAC(HEIGHT_FRAC_BITS)) u_band_high (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_gsq   (w_cfg.high_gsq),
        .i_sumsq (r_s_mh),
        .i_mono  (r_mono[1]),
        .o_x     (w_x_high)
    );

    thb_isqrt #(.RW(RW)) u_sqrt_low (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (w_x_low),
        .o_root (w_rt_low)
    );

    thb_isqrt #(.RW(RW)) u_sqrt_mid (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (w_x_mid),
        .o_root (w_rt_mid)
    );

    thb_isqrt #(.RW(RW)) u_sqrt_high (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (w_x_high),
        .o_root (w_rt_high)
    );

    assign w_rt_min = (w_rt_low < w_rt_mid) ? w_rt_low : w_rt_mid;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lo <= OUT_W'(w_rt_low);
            r_mi <= OUT_W'(w_rt_mid);
            r_lm <= OUT_W'(w_rt_min);
            r_hi <= OUT_W'(w_rt_high);
        end
    end

    assign o_out.valid          = r_vld[TOT-1];
    assign o_out.low_extent     = r_lo;
    assign o_out.mid_extent     = r_mi;
    assign o_out.low_mid_extent = r_lm;
    assign o_out.high_extent    = r_hi;

    a_min_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_lm == r_lo) || (r_lm == r_mi))
        else $error("low_mid extent is neither low nor mid");

    if (RW <= OUT_W) begin : g_chk
        a_min_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_out.valid |-> (r_lm <= r_lo) && (r_lm <= r_mi))
            else $error("low_mid extent exceeds low or mid");

        a_stereo_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_out.valid && !r_mono[TOT-1]) |->
                (r_lo <= CAP_OUT) && (r_mi <= CAP_OUT) && (r_hi <= CAP_OUT))
            else $error("stereo extent above cap");
    end

endmodule

>>> test/tb_waveform_three_band_heights_core.sv
// Testbench for waveform_three_band_heights_core: directed column table, then random
// columns over several gain and mode settings, checked against a behavioral predictor.
// depends on thb_pkg, thb_in_if, thb_out_if and the core
module tb_waveform_three_band_heights_core import thb_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 8;
    localparam int LATENCY     = FRAC + 14;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 100;

    typedef struct {
        bit [LVL_W-1:0] low_l, low_r, mid_l, mid_r, high_l, high_r;
    } t_column;

    typedef struct {
        bit [OUT_W-1:0] low, mid, low_mid, high;
    } t_extents;

    typedef struct {
        bit                    is_write;
        t_cfg_idx              reg_idx;
        bit [CFG_DATA_W-1:0]   value;
        t_column               col;
        bit                    typed;
        t_extents              ext;
    } t_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    thb_in_if  col_if ();
    thb_out_if ext_if ();

    waveform_three_band_heights_core #(
        .HEIGHT_FRAC_BITS(FRAC)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (col_if),
        .o_out      (ext_if)
    );

    t_step            column_plan[$];
    t_extents         expected_extents[$];
    bit [GAIN_W-1:0]  low_gain  = LOW_GAIN_RST;
    bit [GAIN_W-1:0]  mid_gain  = MID_GAIN_RST;
    bit [GAIN_W-1:0]  high_gain = HIGH_GAIN_RST;
    bit               mono      = 1'b0;
    bit               quiet     = 1'b0;
    int               mismatches  = 0;
    int               idle_cycles = 0;
    int               stall_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit [31:0] int_sqrt(bit [63:0] v);
        bit [31:0] r;
        bit [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    // floor of the clamped, scaled height in fixed point
    function automatic bit [OUT_W-1:0] layer_extent(bit [GAIN_W-1:0] gain,
                                                    bit [SUM_W-1:0] energy, bit dbl);
        bit [63:0] g;
        bit [63:0] en;
        bit [63:0] prod;
        bit [63:0] arg;
        bit [31:0] root;
        bit [31:0] cap;
        int        sh;
        g    = 64'(gain);
        en   = 64'(energy);
        prod = g * g * en;
        sh   = 2 * FRAC - 21 + (dbl ? 2 : 0);
        arg  = (sh >= 0) ? (prod << sh) : (prod >> (-sh));
        root = int_sqrt(arg);
        cap  = 32'd255 << (FRAC + (dbl ? 1 : 0));
        return (root < cap) ? root[OUT_W-1:0] : cap[OUT_W-1:0];
    endfunction

    function automatic t_extents column_extents(t_column c);
        bit [SUM_W-1:0] ll, lr, ml, mr, hl, hr;
        bit [SUM_W-1:0] e_low, e_mid, e_high;
        t_extents       x;
        ll = SUM_W'(c.low_l);  lr = SUM_W'(c.low_r);
        ml = SUM_W'(c.mid_l);  mr = SUM_W'(c.mid_r);
        hl = SUM_W'(c.high_l); hr = SUM_W'(c.high_r);
        e_low  = ll * ll + lr * lr;
        e_mid  = ml * ml + mr * mr;
        e_high = e_mid + hl * hl + hr * hr;
        x.low     = layer_extent(low_gain, e_low, mono);
        x.mid     = layer_extent(mid_gain, e_mid, mono);
        x.high    = layer_extent(high_gain, e_high, mono);
        x.low_mid = (x.low < x.mid) ? x.low : x.mid;
        return x;
    endfunction

    function automatic t_column make_column(int ll, int lr, int ml, int mr, int hl, int hr);
        t_column c;
        c.low_l  = LVL_W'(ll); c.low_r  = LVL_W'(lr);
        c.mid_l  = LVL_W'(ml); c.mid_r  = LVL_W'(mr);
        c.high_l = LVL_W'(hl); c.high_r = LVL_W'(hr);
        return c;
    endfunction

    function automatic t_extents make_extents(int lo, int mi, int lm, int hi);
        t_extents e;
        e.low = OUT_W'(lo); e.mid = OUT_W'(mi); e.low_mid = OUT_W'(lm); e.high = OUT_W'(hi);
        return e;
    endfunction

    function automatic void add_item(t_column c);
        t_step s;
        s.is_write = 1'b0;
        s.reg_idx  = CFG_LOW_GAIN;
        s.value    = '0;
        s.col      = c;
        s.typed    = 1'b0;
        s.ext      = make_extents(0, 0, 0, 0);
        column_plan.push_back(s);
    endfunction

    function automatic void add_checked(t_column c, t_extents e);
        t_step s;
        s.is_write = 1'b0;
        s.reg_idx  = CFG_LOW_GAIN;
        s.value    = '0;
        s.col      = c;
        s.typed    = 1'b1;
        s.ext      = e;
        column_plan.push_back(s);
    endfunction

    function automatic void add_write(t_cfg_idx idx, int value);
        t_step s;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.value    = CFG_DATA_W'(value);
        s.col      = make_column(0, 0, 0, 0, 0, 0);
        s.typed    = 1'b0;
        s.ext      = make_extents(0, 0, 0, 0);
        column_plan.push_back(s);
    endfunction

    function automatic bit [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic bit [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return LVL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_column random_column();
        t_column c;
        c.low_l  = pick_level(); c.low_r  = pick_level();
        c.mid_l  = pick_level(); c.mid_r  = pick_level();
        c.high_l = pick_level(); c.high_r = pick_level();
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LOW_GAIN:  low_gain  = value[GAIN_W-1:0];
            CFG_MID_GAIN:  mid_gain  = value[GAIN_W-1:0];
            CFG_HIGH_GAIN: high_gain = value[GAIN_W-1:0];
            CFG_MONO_MODE: mono      = value[0];
            default: ;
        endcase
    endtask

    task automatic settle();
        @(negedge i_clk);
        col_if.valid <= 1'b0;
        while (expected_extents.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_column(t_column c, t_extents e);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            col_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        col_if.valid      <= 1'b1;
        col_if.low_left   <= c.low_l;
        col_if.low_right  <= c.low_r;
        col_if.mid_left   <= c.mid_l;
        col_if.mid_right  <= c.mid_r;
        col_if.high_left  <= c.high_l;
        col_if.high_right <= c.high_r;
        do @(posedge i_clk); while (col_if.ready !== 1'b1);
        expected_extents.push_back(e);
    endtask

    task automatic check_field(string name, bit [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 9);
        if (stall_left != 0) begin
            ext_if.ready <= 1'b0;
            stall_left--;
        end else begin
            ext_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_extents want;
        if (i_rst_n && ext_if.valid === 1'b1 && ext_if.ready === 1'b1) begin
            if (expected_extents.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                want = expected_extents.pop_front();
                check_field("low_extent", want.low, ext_if.low_extent);
                check_field("mid_extent", want.mid, ext_if.mid_extent);
                check_field("low_mid_extent", want.low_mid, ext_if.low_mid_extent);
                check_field("high_extent", want.high, ext_if.high_extent);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((col_if.valid === 1'b1 && col_if.ready === 1'b1) ||
            (ext_if.valid === 1'b1 && ext_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_column c;
        bit      busy;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_LOW_GAIN;
        i_cfg_data        = '0;
        col_if.valid      = 1'b0;
        col_if.low_left   = '0;
        col_if.low_right  = '0;
        col_if.mid_left   = '0;
        col_if.mid_right  = '0;
        col_if.high_left  = '0;
        col_if.high_right = '0;
        ext_if.ready      = 1'b0;
        busy              = 1'b0;

        // reset gains, stereo
        add_checked(make_column(0, 0, 0, 0, 0, 0), make_extents(0, 0, 0, 0));
        add_item(make_column(255, 255, 255, 255, 255, 255));
        add_item(make_column(255, 0, 0, 0, 0, 0));
        add_item(make_column(0, 0, 255, 0, 0, 0));
        add_item(make_column(0, 0, 0, 0, 255, 255));
        add_item(make_column(170, 85, 170, 85, 170, 85));
        add_item(make_column(85, 170, 85, 170, 85, 170));
        add_item(make_column(1, 1, 1, 1, 1, 1));
        add_item(make_column(128, 128, 128, 128, 128, 128));
        // zero gain and full gain
        add_write(CFG_LOW_GAIN, 0);
        add_write(CFG_MID_GAIN, 4095);
        add_write(CFG_HIGH_GAIN, 4095);
        add_checked(make_column(255, 255, 255, 255, 255, 255),
                    make_extents(0, 65280, 0, 65280));
        add_item(make_column(1, 0, 1, 0, 1, 0));
        add_item(make_column(128, 127, 128, 127, 128, 127));
        // mono doubles the clamp
        add_write(CFG_MONO_MODE, 1);
        add_checked(make_column(255, 255, 255, 255, 255, 255),
                    make_extents(0, 130560, 0, 130560));
        add_checked(make_column(0, 0, 0, 0, 0, 0), make_extents(0, 0, 0, 0));
        add_item(make_column(17, 200, 33, 190, 5, 250));
        add_write(CFG_LOW_GAIN, 4095);
        add_write(CFG_MID_GAIN, 0);
        add_write(CFG_HIGH_GAIN, 0);
        add_checked(make_column(255, 255, 255, 255, 255, 255),
                    make_extents(130560, 0, 0, 0));
        add_item(make_column(3, 250, 7, 240, 11, 230));
        // smallest nonzero gains
        add_write(CFG_MONO_MODE, 0);
        add_write(CFG_LOW_GAIN, 1);
        add_write(CFG_MID_GAIN, 1);
        add_write(CFG_HIGH_GAIN, 1);
        add_item(make_column(255, 255, 255, 255, 255, 255));
        add_item(make_column(255, 0, 255, 0, 255, 0));
        add_write(CFG_LOW_GAIN, int'(LOW_GAIN_RST));
        add_write(CFG_MID_GAIN, int'(MID_GAIN_RST));
        add_write(CFG_HIGH_GAIN, int'(HIGH_GAIN_RST));
        add_item(make_column(255, 0, 15, 240, 51, 204));
        add_item(make_column(64, 192, 100, 20, 240, 16));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (column_plan[k]) begin
            if (column_plan[k].is_write) begin
                if (busy) settle();
                busy = 1'b0;
                write_reg(column_plan[k].reg_idx, column_plan[k].value);
            end else begin
                send_column(column_plan[k].col, column_plan[k].typed ?
                            column_plan[k].ext : column_extents(column_plan[k].col));
                busy = 1'b1;
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            quiet = (p == PHASES - 1);
            write_reg(CFG_LOW_GAIN, pick_gain());
            write_reg(CFG_MID_GAIN, pick_gain());
            write_reg(CFG_HIGH_GAIN, pick_gain());
            write_reg(CFG_MONO_MODE, CFG_DATA_W'(p % 2));
            repeat (PHASE_ITEMS) begin
                c = random_column();
                send_column(c, column_extents(c));
            end
        end
        settle();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> waveform_three_band_heights_core.f
rtl/thb_pkg.sv
rtl/thb_in_if.sv
rtl/thb_out_if.sv
rtl/thb_cfg.sv
rtl/thb_band.sv
rtl/thb_isqrt.sv
rtl/waveform_three_band_heights_core.sv
test/tb_waveform_three_band_heights_core.sv
